FILE: hw/rtl/drafd_pkg.sv
`timescale 1ns / 1ps
package drafd_pkg;

    localparam int RING_DEPTH_DEF = 32;
    localparam int MARK_W         = 6;
    localparam int TIME_W         = 31;
    localparam int SLOT_W         = 5;
    localparam int ALPHA_W        = 8;
    localparam int CMD_Q_DEPTH    = 2;
    localparam int RES_Q_DEPTH    = 4;

    localparam logic [MARK_W-1:0] MARK_RST = 6'd32;

    // fade: alpha = floor(255 * (1000 - t) / 1000), divide by reciprocal multiply
    localparam int          FADE_MS     = 1000;
    localparam int          Y_W         = 18;
    localparam int          RECIP_SHIFT = 28;
    localparam logic [18:0] RECIP       = 19'd268436;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_INSPECT = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;
    localparam logic [1:0] ACT_RSVD    = 2'd3;

    localparam logic [2:0] KIND_ALLOC   = 3'd0;
    localparam logic [2:0] KIND_MOVED   = 3'd1;
    localparam logic [2:0] KIND_DRAW    = 3'd2;
    localparam logic [2:0] KIND_FADED   = 3'd3;
    localparam logic [2:0] KIND_FREED   = 3'd4;
    localparam logic [2:0] KIND_EMPTY   = 3'd5;
    localparam logic [2:0] KIND_IGNORED = 3'd6;
    localparam logic [2:0] KIND_CLEARED = 3'd7;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_INSPECT = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_IGNORE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]        action;
        logic              ring_select;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now_time;
    } t_in;

    typedef struct packed {
        logic [2:0]         kind;
        logic [SLOT_W-1:0]  slot_out;
        logic [SLOT_W-1:0]  fade_slot;
        logic [ALPHA_W-1:0] alpha;
        logic               last;
    } t_out;

    typedef struct packed {
        t_op               op;
        logic              ring_select;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now_time;
    } t_cmd;

endpackage

FILE: hw/rtl/drafd_fifo.sv
`timescale 1ns / 1ps
module drafd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_rd;
    logic [AW-1:0]    r_wr;
    logic [CW-1:0]    r_cnt;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push_ok && !w_pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop_ok && !w_push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/drafd_front.sv
`timescale 1ns / 1ps
module drafd_front
    import drafd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  t_in               i_item,
    input  logic [MARK_W-1:0] i_ring_size,
    input  logic              i_cmd_pop,
    output logic              o_cmd_empty,
    output t_cmd              o_cmd
);
    t_cmd                   w_cmd;
    logic [$bits(t_cmd)-1:0] w_q_out;

    // classify: everything that answers "ignored" is settled here
    always_comb begin
        w_cmd.ring_select = i_item.ring_select;
        w_cmd.slot        = i_item.slot;
        w_cmd.now_time    = i_item.now_time;
        unique case (i_item.action)
            ACT_ALLOC: begin
                w_cmd.op = (i_ring_size == '0 || i_item.now_time == '0) ? OP_IGNORE
                                                                         : OP_ALLOC;
            end
            ACT_INSPECT: begin
                w_cmd.op = (i_ring_size == '0 || MARK_W'(i_item.slot) >= i_ring_size)
                           ? OP_IGNORE : OP_INSPECT;
            end
            ACT_CLEAR: begin
                w_cmd.op = OP_CLEAR;
            end
            ACT_RSVD: begin
                w_cmd.op = OP_IGNORE;
            end
            default: begin
                w_cmd.op = OP_IGNORE;
            end
        endcase
    end

    drafd_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (w_q_out),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(w_q_out);

endmodule

FILE: hw/rtl/drafd_back.sv
`timescale 1ns / 1ps
module drafd_back
    import drafd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MARK_W-1:0] i_cfg_wdata,
    output logic [MARK_W-1:0] o_ring_size,
    input  logic              i_cmd_empty,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic              o_res_push,
    output t_out              o_res,
    input  logic              i_res_full
);
    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WALK  = 7'b0000010,
        S_FADE  = 7'b0000100,
        S_FWALK = 7'b0001000,
        S_MOVE  = 7'b0010000,
        S_ALLOC = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state                 r_state;
    logic [MARK_W-1:0]      r_mark;
    logic [TIME_W-1:0]      r_nst [RING_DEPTH];
    logic [TIME_W-1:0]      r_fst [RING_DEPTH];
    logic [RING_DEPTH-1:0]  r_nv;
    logic [RING_DEPTH-1:0]  r_fv;
    logic [IW-1:0]          r_nhead;
    logic [IW-1:0]          r_fhead;
    logic [TIME_W-1:0]      r_now;
    logic [TIME_W-1:0]      r_old;
    logic [TIME_W-1:0]      r_fold;
    logic [IW-1:0]          r_h;
    logic [IW-1:0]          r_i;
    logic [IW-1:0]          r_ev;
    logic [IW-1:0]          r_fh;
    logic [IW-1:0]          r_fi;
    logic [MARK_W-1:0]      r_k;
    logic [MARK_W-1:0]      r_fk;
    logic                   r_evh;
    logic [2:0]             r_kind;
    logic [IW-1:0]          r_slot;
    logic [Y_W-1:0]         r_y;

    logic [MARK_W-1:0]      w_m;
    logic [IW-1:0]          w_nh;
    logic [IW-1:0]          w_fh;
    logic [IW-1:0]          w_sidx;
    logic [IW-1:0]          w_nra;
    logic [IW-1:0]          w_fra;
    logic [TIME_W-1:0]      w_nrd;
    logic [TIME_W-1:0]      w_frd;
    logic                   w_nrv;
    logic                   w_frv;
    logic [TIME_W-1:0]      w_t;
    logic [9:0]             w_x;
    logic [Y_W-1:0]         w_y;
    logic [Y_W+18:0]        w_prod;
    logic [6:0]             w_slot7;

    function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i, input logic [MARK_W-1:0] m);
        logic [6:0] s;
        s = 7'(i) + 7'd1;
        return (s >= 7'(m)) ? '0 : s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] clip(input logic [IW-1:0] i, input logic [MARK_W-1:0] m);
        return (7'(i) >= 7'(m)) ? '0 : i;
    endfunction

    assign w_m         = (r_mark > MARK_W'(RING_DEPTH)) ? MARK_W'(RING_DEPTH) : r_mark;
    assign o_ring_size = w_m;
    assign w_nh        = clip(r_nhead, w_m);
    assign w_fh        = clip(r_fhead, w_m);
    assign w_slot7     = 7'(i_cmd.slot);
    assign w_sidx      = w_slot7[IW-1:0];

    // one read address per ring each cycle
    assign w_nra = (r_state == S_WALK) ? r_i
                 : (i_cmd.op == OP_INSPECT) ? w_sidx : w_nh;
    assign w_fra = (r_state == S_FADE) ? w_fh
                 : (r_state == S_FWALK) ? r_fi : w_sidx;
    assign w_nrd = r_nst[w_nra];
    assign w_nrv = r_nv[w_nra];
    assign w_frd = r_fst[w_fra];
    assign w_frv = r_fv[w_fra];

    // elapsed time, clamped at zero when time runs backward
    assign w_t    = (i_cmd.now_time >= w_frd) ? i_cmd.now_time - w_frd : '0;
    assign w_x    = 10'(FADE_MS) - w_t[9:0];
    assign w_y    = {w_x, 8'b0} - Y_W'(w_x);
    assign w_prod = 37'(r_y) * 37'(RECIP);

    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty && !i_cfg_we;

    always_comb begin
        o_res_push = 1'b0;
        o_res      = '0;
        unique case (r_state)
            S_MOVE: begin
                o_res_push      = !i_res_full;
                o_res.kind      = KIND_MOVED;
                o_res.slot_out  = SLOT_W'(r_ev);
                o_res.fade_slot = SLOT_W'(r_fh);
            end
            S_ALLOC: begin
                o_res_push     = !i_res_full;
                o_res.kind     = KIND_ALLOC;
                o_res.slot_out = SLOT_W'(r_h);
                o_res.last     = 1'b1;
            end
            S_EMIT: begin
                o_res_push     = !i_res_full;
                o_res.kind     = r_kind;
                o_res.slot_out = SLOT_W'(r_slot);
                o_res.alpha    = (r_kind == KIND_FADED)
                                 ? w_prod[RECIP_SHIFT+ALPHA_W-1:RECIP_SHIFT] : '0;
                o_res.last     = 1'b1;
            end
            default: begin
                o_res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mark  <= MARK_RST;
            r_nv    <= '0;
            r_fv    <= '0;
            r_nhead <= '0;
            r_fhead <= '0;
        end else if (i_cfg_we) begin
            r_mark  <= i_cfg_wdata;
            r_nv    <= '0;
            r_fv    <= '0;
            r_nhead <= '0;
            r_fhead <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_now  <= i_cmd.now_time;
                        unique case (i_cmd.op)
                            OP_ALLOC: begin
                                r_h   <= w_nh;
                                r_old <= w_nrd;
                                r_i   <= nxt(w_nh, w_m);
                                r_k   <= MARK_W'(1);
                                r_ev  <= w_nh;
                                r_evh <= 1'b1;
                                if (w_nrv && w_nrd != i_cmd.now_time && w_m > MARK_W'(1)) begin
                                    r_state <= S_WALK;
                                end else if (w_nrv) begin
                                    r_state <= S_FADE;
                                end else begin
                                    r_state <= S_ALLOC;
                                end
                            end
                            OP_INSPECT: begin
                                r_slot  <= w_sidx;
                                r_y     <= w_y;
                                r_state <= S_EMIT;
                                if (!i_cmd.ring_select) begin
                                    r_kind <= w_nrv ? KIND_DRAW : KIND_EMPTY;
                                end else if (!w_frv) begin
                                    r_kind <= KIND_EMPTY;
                                end else if (w_t < TIME_W'(FADE_MS)) begin
                                    r_kind <= KIND_FADED;
                                end else begin
                                    r_kind         <= KIND_FREED;
                                    r_fv[w_sidx]   <= 1'b0;
                                end
                            end
                            OP_CLEAR: begin
                                r_slot  <= '0;
                                r_kind  <= KIND_CLEARED;
                                r_nv    <= '0;
                                r_fv    <= '0;
                                r_nhead <= '0;
                                r_fhead <= '0;
                                r_state <= S_EMIT;
                            end
                            OP_IGNORE: begin
                                r_slot  <= '0;
                                r_kind  <= KIND_IGNORED;
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    r_state <= S_FADE;
                    if (w_nrv && w_nrd == r_old) begin
                        r_ev  <= r_i;
                        r_evh <= 1'b0;
                    end else begin
                        r_ev  <= r_h;
                        r_evh <= 1'b1;
                    end
                end
                S_FADE: begin
                    r_fh   <= w_fh;
                    r_fold <= w_frd;
                    r_fi   <= nxt(w_fh, w_m);
                    r_fk   <= MARK_W'(1);
                    if (w_frv && w_frd != r_now && w_m > MARK_W'(1)) begin
                        r_state <= S_FWALK;
                    end else begin
                        r_state <= S_MOVE;
                    end
                end
                S_FWALK: begin
                    if (w_frv && w_frd == r_fold) begin
                        r_fv[r_fi] <= 1'b0;
                        if (7'(r_fk) + 7'd1 < 7'(w_m)) begin
                            r_fk <= r_fk + 1'b1;
                            r_fi <= nxt(r_fi, w_m);
                        end else begin
                            r_state <= S_MOVE;
                        end
                    end else begin
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    if (!i_res_full) begin
                        r_fst[r_fh] <= r_now;
                        r_fv[r_fh]  <= 1'b1;
                        r_fhead     <= nxt(r_fh, w_m);
                        r_nv[r_ev]  <= 1'b0;
                        if (r_evh) begin
                            r_state <= S_ALLOC;
                        end else if (7'(r_k) + 7'd1 < 7'(w_m)) begin
                            r_k     <= r_k + 1'b1;
                            r_i     <= nxt(r_i, w_m);
                            r_state <= S_WALK;
                        end else begin
                            r_ev    <= r_h;
                            r_evh   <= 1'b1;
                            r_state <= S_FADE;
                        end
                    end
                end
                S_ALLOC: begin
                    if (!i_res_full) begin
                        r_nst[r_h] <= r_now;
                        r_nv[r_h]  <= 1'b1;
                        r_nhead    <= nxt(r_h, w_m);
                        r_state    <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/decal_ring_allocator_with_fade.sv
`timescale 1ns / 1ps
// An item passes the command queue, the sequencer and the result queue on its way to the outputs.
// Inspect, clear and ignored items pass the sequencer's idle and emit states.
// Allocate: idle, alloc; evicting only the head adds fade, move; each walk step adds walk, fade,
// move, and a walk to the ring end adds fade, move; each fade-ring drop adds an fwalk step, as
// does the step that sees the group end. Results stall the sequencer while the result queue is
// full. Reset (i_rst_n low, synchronous): rings empty, heads 0, mark_count 32, queues empty.
module decal_ring_allocator_with_fade
    import drafd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input queue side: transfer on push && !full
    input  logic              i_push,
    output logic              o_full,
    input  t_in               i_item,
    // result queue side: transfer on pop && !empty
    output logic              o_empty,
    input  logic              i_pop,
    output t_out              o_item,
    // mark_count write; also empties both rings
    input  logic              i_cfg_we,
    input  logic [MARK_W-1:0] i_cfg_wdata
);
    logic [MARK_W-1:0]       w_ring_size;
    logic                    w_cmd_empty;
    logic                    w_cmd_pop;
    t_cmd                    w_cmd;
    logic                    w_res_push;
    logic                    w_res_full;
    t_out                    w_res;
    logic [$bits(t_out)-1:0] w_res_q;

    // front: classifies items against the ring size and queues them
    drafd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_item      (i_item),
        .i_ring_size (w_ring_size),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd_empty (w_cmd_empty),
        .o_cmd       (w_cmd)
    );

    // back: ring state and the eviction sequencer
    drafd_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ring_size (w_ring_size),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    // result queue decouples the sequencer from the consumer
    drafd_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_data  (w_res_q),
        .o_empty (o_empty)
    );

    assign o_item = t_out'(w_res_q);

    // result queue comes out of reset empty
    a_rst_empty: assert property (@(posedge i_clk) $rose(i_rst_n) |-> o_empty)
        else $error("result queue not empty after reset");

    // sequencer never pushes into a full result queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed while queue full");

    // sequencer only takes commands that are there
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("command popped from empty queue");

endmodule
